/* hdl/graph_infection_table_unit_defines.svh */
// Assertion macros used by the checker file of the infection table.
`ifndef GRAPH_INFECTION_TABLE_UNIT_DEFINES_SVH
`define GRAPH_INFECTION_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define GIT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("graph_infection_table_unit: check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define GIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("graph_infection_table_unit: check failed");

`endif

/* hdl/git_pkg.sv */
// Types and constants of the graph infection table.
package git_pkg;

	localparam int REQ_W  = 3;
	localparam int NODE_W = 4;
	localparam int ROW_W  = 16;
	localparam int HN_W   = 4;
	localparam int CFG_W  = 5;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [REQ_W-1:0] REQ_LOAD_ROW     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_MARK_CARRIER = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MARK_ACTIVE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DISCONNECT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PROBE        = 3'd4;

	localparam logic [APB_AW-1:0] ADDR_NODE_COUNT = 3'd0;
	localparam logic [CFG_W-1:0]  NODE_COUNT_RST  = 5'd16;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [NODE_W-1:0] node;
		logic [ROW_W-1:0]  row_bits;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [HN_W-1:0]   healthy_neighbor;
		logic [ROW_W-1:0]  neighbor_row;
		logic [ROW_W-1:0]  active_map;
		logic              carrier_pending;
		logic              bad_node;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

/* hdl/graph_infection_table_unit.sv */
// Graph infection table: adjacency matrix with carrier and active marks per node.
// One request is taken at a time; req_ready is low from the transfer until the
// result is handed to the output register. A request passes through an execute
// step, a row load and the search, then its result is registered at the output;
// a bad node skips the row load and the search. The result is in the output
// register by the time the next request can be taken. The time a request takes is
// set by the search for the lowest non-carrier neighbor, which shifts the candidate
// row through a one-bit test each cycle.
// A result waiting on rsp_ready holds the block in its last step; the next
// request may be taken as soon as that result sits in the output register.
// Adjacency rows and marks sit in flip-flops cleared by reset; there is no
// clearing pass. node_count is written over the APB port at byte address 0.
module graph_infection_table_unit #(
	parameter int MAX_NODES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  git_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output git_pkg::rsp_t               rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [git_pkg::APB_AW-1:0]  paddr,
	input  logic [git_pkg::APB_DW-1:0]  pwdata,
	output logic [git_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import git_pkg::*;

	localparam int NW = MAX_NODES;
	localparam int IW = $clog2(MAX_NODES);
	localparam int CW = ($clog2(MAX_NODES + 1) > CFG_W) ? $clog2(MAX_NODES + 1) : CFG_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]  node_count_q;
	logic [NW-1:0]     adj_q [MAX_NODES];
	logic [NW-1:0]     carrier_q;
	logic [NW-1:0]     active_q;

	logic [REQ_W-1:0]  req_type_q;
	logic [NODE_W-1:0] node_q;
	logic [ROW_W-1:0]  row_bits_q;
	logic [NW-1:0]     row_q;
	logic [NW-1:0]     healthy_q;
	logic [IW-1:0]     idx_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CW-1:0]     live_n;
	logic [NW-1:0]     live_mask;
	logic [IW-1:0]     node_idx;
	logic [NW-1:0]     node_onehot;
	logic [NW-1:0]     row_in;
	logic              bad;
	logic              cfg_wr;
	logic              scan_done;

	logic              accept;
	logic              do_update;
	logic              load_row;
	logic              scan_step;
	logic              load_out;

	// Effective node count and the mask of nodes in use
	always_comb begin
		if (CW'(node_count_q) > CW'(MAX_NODES)) begin
			live_n = CW'(MAX_NODES);
		end else begin
			live_n = CW'(node_count_q);
		end
		for (int i = 0; i < NW; i++) begin
			live_mask[i] = (CW'(i) < live_n);
		end
	end

	assign node_idx    = IW'(node_q);
	assign node_onehot = {{(NW-1){1'b0}}, 1'b1} << node_idx;
	assign row_in      = NW'(row_bits_q) & live_mask;
	assign bad         = (CW'(node_q) >= live_n);
	assign scan_done   = (healthy_q == '0) || healthy_q[0];

	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_NODE_COUNT);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NODE_COUNT) ? APB_DW'(node_count_q) : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (req_valid) state_d = ST_EXEC;
			ST_EXEC:   state_d = bad ? ST_FINISH : ST_LOAD;
			ST_LOAD:   state_d = ST_SCAN;
			ST_SCAN:   if (scan_done) state_d = ST_FINISH;
			ST_FINISH: if (!rsp_valid_q || rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control strobes
	always_comb begin
		req_ready = 1'b0;
		do_update = 1'b0;
		load_row  = 1'b0;
		scan_step = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_EXEC:   do_update = !bad;
			ST_LOAD:   load_row  = 1'b1;
			ST_SCAN:   scan_step = !scan_done;
			ST_FINISH: load_out  = !rsp_valid_q || rsp_ready;
			default:   ;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_COUNT_RST;
			carrier_q    <= '0;
			active_q     <= '0;
			rsp_valid_q  <= 1'b0;
			for (int r = 0; r < MAX_NODES; r++) begin
				adj_q[r] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				node_count_q <= pwdata[CFG_W-1:0];
			end
			if (do_update) begin
				case (req_type_q)
					REQ_LOAD_ROW:     adj_q[node_idx] <= row_in;
					REQ_MARK_CARRIER: carrier_q <= carrier_q | node_onehot;
					REQ_MARK_ACTIVE:  active_q <= active_q | node_onehot;
					REQ_DISCONNECT: begin
						// drop the column everywhere and clear the row itself
						for (int r = 0; r < MAX_NODES; r++) begin
							if (IW'(r) == node_idx) begin
								adj_q[r] <= '0;
							end else begin
								adj_q[r] <= adj_q[r] & ~node_onehot;
							end
						end
					end
					default: ;
				endcase
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: request capture, row load and the one-bit-per-cycle search
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			node_q     <= req.node;
			row_bits_q <= req.row_bits;
		end
		if (state_q == ST_EXEC && bad) begin
			row_q     <= '0;
			healthy_q <= '0;
			idx_q     <= '0;
		end
		if (load_row) begin
			row_q     <= adj_q[node_idx] & live_mask;
			healthy_q <= adj_q[node_idx] & live_mask & ~carrier_q;
			idx_q     <= '0;
		end
		if (scan_step) begin
			healthy_q <= healthy_q >> 1;
			idx_q     <= idx_q + 1'b1;
		end
		if (load_out) begin
			rsp_q.found            <= healthy_q[0];
			rsp_q.healthy_neighbor <= healthy_q[0] ? HN_W'(idx_q) : '0;
			rsp_q.neighbor_row     <= ROW_W'(row_q);
			rsp_q.active_map       <= ROW_W'(active_q & live_mask);
			rsp_q.carrier_pending  <= |(carrier_q & ~active_q & live_mask);
			rsp_q.bad_node         <= bad;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/git_checker.sv */
// Port-level checks of the graph infection table and their bind.
`include "graph_infection_table_unit_defines.svh"

module git_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input git_pkg::rsp_t rsp
);
	import git_pkg::*;

	// a taken request keeps the block busy for at least the next cycle
	`GIT_ASSERT_NEXT(a_busy_after_transfer, req_valid && req_ready, !req_ready)

	// a reported neighbor is really in the row, and no neighbor means index zero
	`GIT_ASSERT_NOW(a_found_in_row, rsp_valid && rsp.found, rsp.neighbor_row[rsp.healthy_neighbor])
	`GIT_ASSERT_NOW(a_none_zero, rsp_valid && !rsp.found, rsp.healthy_neighbor == '0)

	// a bad node reports no row and no neighbor
	`GIT_ASSERT_NOW(a_bad_empty, rsp_valid && rsp.bad_node, !rsp.found && rsp.neighbor_row == '0)

	// a stalled result holds
	`GIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind graph_infection_table_unit git_checker u_git_checker (.*);
